// ----- design/slhs_pkg.sv -----
`default_nettype none
package slhs_pkg;

  localparam int MAX_PATTERN_LEN = 32;
  localparam int BYTE_W          = 8;
  localparam int PAT_W           = MAX_PATTERN_LEN * BYTE_W;
  localparam int LEN_W           = $clog2(MAX_PATTERN_LEN + 1);
  localparam int IDX_W           = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int PLEN_CFG_W      = 6;
  localparam int TICK_W          = 16;
  localparam int IDLE_W          = 17;
  localparam int CFG_W           = 64;
  localparam int CFG_IDX_W       = 3;

  localparam logic [IDLE_W-1:0]     IDLE_MAX            = '1;
  localparam logic [TICK_W-1:0]     IDLE_LIMIT_RST      = 16'd2000;
  localparam logic [TICK_W-1:0]     BEACON_PERIOD_RST   = 16'd500;
  localparam logic [PLEN_CFG_W-1:0] PATTERN_LEN_RST     = 6'd32;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic BEACON_START_ROOT = 1'b0;
  localparam logic BEACON_CONNECTED  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IDLE_LIMIT    = 3'd0,
    CFG_BEACON_PERIOD = 3'd1,
    CFG_PATTERN_LEN   = 3'd2,
    CFG_PATTERN_W0    = 3'd3,
    CFG_PATTERN_W1    = 3'd4,
    CFG_PATTERN_W2    = 3'd5,
    CFG_PATTERN_W3    = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    LINK_WAIT = 2'b01,
    LINK_UP   = 2'b10
  } link_state_t;

  typedef struct packed {
    logic              req_type;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic link_connected;
    logic handshake_matched;
    logic idle_dropped;
    logic beacon_sent;
    logic beacon_kind;
  } result_t;

  typedef struct packed {
    logic push;
    logic clr_fill;
  } win_ctl_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [PLEN_CFG_W-1:0] len);
    logic [LEN_W-1:0] res;
    if (len == '0) begin
      res = LEN_W'(1);
    end else if (PLEN_CFG_W'(MAX_PATTERN_LEN) < len) begin
      res = LEN_W'(MAX_PATTERN_LEN);
    end else begin
      res = LEN_W'(len);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- design/slhs_window.sv -----
`default_nettype none
module slhs_window (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire slhs_pkg::win_ctl_t          ctl,
  input  wire logic [7:0]                  rx_byte,
  input  wire logic [slhs_pkg::LEN_W-1:0]  len,
  input  wire logic [slhs_pkg::PAT_W-1:0]  pattern,
  output logic                             match
);
  import slhs_pkg::*;

  // sh_r[0] is the newest byte, sh_r[k] the one k bytes older
  logic [BYTE_W-1:0] sh_r   [MAX_PATTERN_LEN];
  logic [BYTE_W-1:0] sh_nxt [MAX_PATTERN_LEN];
  logic [LEN_W-1:0]  fill_r;
  logic [LEN_W-1:0]  fill_nxt;
  logic              eq_all;

  always_comb begin
    sh_nxt[0] = rx_byte;
    for (int k = 1; k < MAX_PATTERN_LEN; k++) begin
      sh_nxt[k] = sh_r[k-1];
    end
  end

  assign fill_nxt = (fill_r == LEN_W'(MAX_PATTERN_LEN)) ? fill_r : fill_r + LEN_W'(1);

  always_comb begin
    logic [LEN_W-1:0] pos;
    logic [IDX_W-1:0] idx;
    eq_all = 1'b1;
    pos    = '0;
    idx    = '0;
    for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
      if (LEN_W'(k) < len) begin
        pos = len - LEN_W'(k) - LEN_W'(1);
        idx = pos[IDX_W-1:0];
        if (sh_nxt[k] != pattern[idx*BYTE_W +: BYTE_W]) begin
          eq_all = 1'b0;
        end
      end
    end
  end

  assign match = eq_all && (fill_nxt >= len);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      sh_r <= sh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (ctl.clr_fill) begin
      fill_r <= '0;
    end else if (ctl.push) begin
      fill_r <= fill_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/slhs_ctrl.sv -----
`default_nettype none
module slhs_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         fire,
  input  wire slhs_pkg::item_t              item,
  input  wire logic [slhs_pkg::TICK_W-1:0]  idle_limit,
  input  wire logic [slhs_pkg::TICK_W-1:0]  beacon_period,
  input  wire logic                         match,
  output slhs_pkg::win_ctl_t                win_ctl,
  output slhs_pkg::result_t                 res
);
  import slhs_pkg::*;

  link_state_t       link_r, link_nxt;
  logic [IDLE_W-1:0] idle_r, idle_nxt, idle_inc;
  logic [TICK_W-1:0] bwait_r, bwait_nxt, bwait_eff, period_eff;
  logic              is_byte, push, matched, dropped, sent;

  assign is_byte    = (item.req_type == REQ_BYTE);
  assign push       = fire && is_byte && (link_r == LINK_WAIT);
  assign idle_inc   = (idle_r == IDLE_MAX) ? idle_r : idle_r + IDLE_W'(1);
  assign period_eff = (beacon_period == '0) ? TICK_W'(1) : beacon_period;

  always_comb begin
    link_nxt  = link_r;
    idle_nxt  = idle_r;
    bwait_nxt = bwait_r;
    bwait_eff = bwait_r;
    matched   = 1'b0;
    dropped   = 1'b0;
    sent      = 1'b0;
    if (is_byte) begin
      idle_nxt = '0;
      if (push && match) begin
        link_nxt = LINK_UP;
        matched  = 1'b1;
      end
    end else begin
      idle_nxt = idle_inc;
      if ((link_r == LINK_UP) && (idle_inc > IDLE_W'(idle_limit))) begin
        link_nxt  = LINK_WAIT;
        idle_nxt  = '0;
        bwait_eff = '0;
        dropped   = 1'b1;
      end
      if (bwait_eff == '0) begin
        sent      = 1'b1;
        bwait_nxt = period_eff - TICK_W'(1);
      end else begin
        bwait_nxt = bwait_eff - TICK_W'(1);
      end
    end
  end

  assign win_ctl.push     = push;
  assign win_ctl.clr_fill = fire && (dropped || matched);

  assign res.link_connected    = (link_nxt == LINK_UP);
  assign res.handshake_matched = matched;
  assign res.idle_dropped      = dropped;
  assign res.beacon_sent       = sent;
  assign res.beacon_kind       = (sent && (link_nxt == LINK_UP)) ? BEACON_CONNECTED
                                                                 : BEACON_START_ROOT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r  <= LINK_WAIT;
      idle_r  <= '0;
      bwait_r <= '0;
    end else if (fire) begin
      link_r  <= link_nxt;
      idle_r  <= idle_nxt;
      bwait_r <= bwait_nxt;
    end
  end

  a_drop_restarts_beacon: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && dropped) |=> (bwait_r == period_eff - TICK_W'(1)))
    else $error("beacon counter not reloaded after idle drop");

  a_match_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    matched |-> (link_r == LINK_WAIT))
    else $error("handshake match while connected");

  a_idle_zero_after_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_byte) |=> (idle_r == '0))
    else $error("idle counter not cleared by byte");

endmodule
`default_nettype wire

// ----- design/serial_link_handshake_supervisor_top.sv -----
// A transaction accepted into the input register moves on to the result register
// and is offered on the result channel from there.
// Throughput: one transaction per cycle; the input stalls only while the input
// register and the result register are both full and the output is stalled.
// Reset: synchronous active-low rst_n; link waiting, window empty, counters zero,
// registers at their default values (beacon due on the first tick).
`default_nettype none
module serial_link_handshake_supervisor_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_req_type,
  input  wire logic [7:0]                      in_rx_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_link_connected,
  output logic                                 out_handshake_matched,
  output logic                                 out_idle_dropped,
  output logic                                 out_beacon_sent,
  output logic                                 out_beacon_kind,
  input  wire logic                            cfg_we,
  input  wire logic [slhs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [slhs_pkg::CFG_W-1:0]      cfg_wdata
);
  import slhs_pkg::*;

  logic [TICK_W-1:0]     idle_limit_r;
  logic [TICK_W-1:0]     beacon_period_r;
  logic [PLEN_CFG_W-1:0] pattern_len_r;
  logic [CFG_W-1:0]      pat_w0_r, pat_w1_r, pat_w2_r, pat_w3_r;
  logic [PAT_W-1:0]      pattern;

  item_t    s1_item_r;
  logic     s1_valid_r;
  logic     out_valid_r;
  result_t  out_res_r;
  result_t  res;
  win_ctl_t win_ctl;
  logic     out_ready, fire, in_fire, match;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_limit_r    <= IDLE_LIMIT_RST;
      beacon_period_r <= BEACON_PERIOD_RST;
      pattern_len_r   <= PATTERN_LEN_RST;
      pat_w0_r        <= '0;
      pat_w1_r        <= '0;
      pat_w2_r        <= '0;
      pat_w3_r        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDLE_LIMIT:    idle_limit_r    <= cfg_wdata[TICK_W-1:0];
        CFG_BEACON_PERIOD: beacon_period_r <= cfg_wdata[TICK_W-1:0];
        CFG_PATTERN_LEN:   pattern_len_r   <= cfg_wdata[PLEN_CFG_W-1:0];
        CFG_PATTERN_W0:    pat_w0_r        <= cfg_wdata;
        CFG_PATTERN_W1:    pat_w1_r        <= cfg_wdata;
        CFG_PATTERN_W2:    pat_w2_r        <= cfg_wdata;
        CFG_PATTERN_W3:    pat_w3_r        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign pattern = PAT_W'({pat_w3_r, pat_w2_r, pat_w1_r, pat_w0_r});

  assign out_ready = !out_valid_r || !out_stall;
  assign fire      = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_fire   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.req_type <= in_req_type;
      s1_item_r.rx_byte  <= in_rx_byte;
    end
  end

  slhs_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (win_ctl),
    .rx_byte (s1_item_r.rx_byte),
    .len     (eff_len(pattern_len_r)),
    .pattern (pattern),
    .match   (match)
  );

  slhs_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .item          (s1_item_r),
    .idle_limit    (idle_limit_r),
    .beacon_period (beacon_period_r),
    .match         (match),
    .win_ctl       (win_ctl),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_link_connected    = out_res_r.link_connected;
  assign out_handshake_matched = out_res_r.handshake_matched;
  assign out_idle_dropped      = out_res_r.idle_dropped;
  assign out_beacon_sent       = out_res_r.beacon_sent;
  assign out_beacon_kind       = out_res_r.beacon_kind;

  a_match_connects: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.handshake_matched) |-> out_res_r.link_connected)
    else $error("match without connected link");

  a_drop_beacon: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.idle_dropped) |->
      (out_res_r.beacon_sent && !out_res_r.link_connected &&
       (out_res_r.beacon_kind == BEACON_START_ROOT)))
    else $error("idle drop without start-root beacon");

  a_fire_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("transaction lost between stages");

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import slhs_pkg::*;

  localparam int unsigned RAND_ITEMS  = 600;
  localparam int unsigned PHASE_ITEMS = 60;
  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned DRAIN_SLACK = 3;
  localparam int unsigned END_SLACK   = 10;

  typedef struct packed {
    logic    on;
    result_t want;
  } pin_t;

  typedef struct packed {
    logic        is_cfg;
    cfg_idx_t    sel;
    logic [63:0] wdata;
    item_t       item;
    logic        on;
    result_t     want;
  } step_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_req_type;
  logic [7:0]           in_rx_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_link_connected;
  logic                 out_handshake_matched;
  logic                 out_idle_dropped;
  logic                 out_beacon_sent;
  logic                 out_beacon_kind;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  serial_link_handshake_supervisor_top u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_req_type           (in_req_type),
    .in_rx_byte            (in_rx_byte),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_link_connected    (out_link_connected),
    .out_handshake_matched (out_handshake_matched),
    .out_idle_dropped      (out_idle_dropped),
    .out_beacon_sent       (out_beacon_sent),
    .out_beacon_kind       (out_beacon_kind),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  // supervisor shadow: configuration
  logic [TICK_W-1:0]     lim_idle;
  logic [TICK_W-1:0]     beacon_period;
  logic [PLEN_CFG_W-1:0] pat_len;
  logic [PAT_W-1:0]      pat_bytes;

  // supervisor shadow: state
  link_state_t       sup_link;
  logic [7:0]        sup_window [MAX_PATTERN_LEN];
  int unsigned       sup_fill;
  logic [IDLE_W-1:0] sup_idle;
  logic [TICK_W-1:0] sup_wait;

  result_t   pending_results [$];
  pin_t      pin_q [$];
  step_row_t dir_steps [$];

  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned cfg_writes;
  int unsigned phases;
  int unsigned n_matched;
  int unsigned n_dropped;
  int unsigned n_beacons;
  int unsigned n_beacons_up;
  int unsigned stuck;
  int unsigned hold_reqs;
  int unsigned hold_seen;
  int unsigned hold_left;
  logic        quiet;

  string field_name [5] = '{"beacon_kind", "beacon_sent", "idle_dropped",
                            "handshake_matched", "link_connected"};

  always #2 clk = ~clk;

  function automatic void reset_supervisor();
    lim_idle      = IDLE_LIMIT_RST;
    beacon_period = BEACON_PERIOD_RST;
    pat_len       = PATTERN_LEN_RST;
    pat_bytes     = '0;
    sup_link      = LINK_WAIT;
    sup_fill      = 0;
    sup_idle      = '0;
    sup_wait      = '0;
    foreach (sup_window[i]) sup_window[i] = '0;
  endfunction

  function automatic void apply_reg(cfg_idx_t sel, logic [CFG_W-1:0] val);
    case (sel)
      CFG_IDLE_LIMIT:    lim_idle = val[TICK_W-1:0];
      CFG_BEACON_PERIOD: beacon_period = val[TICK_W-1:0];
      CFG_PATTERN_LEN:   pat_len = val[PLEN_CFG_W-1:0];
      CFG_PATTERN_W0:    pat_bytes[0*CFG_W +: CFG_W] = val;
      CFG_PATTERN_W1:    pat_bytes[1*CFG_W +: CFG_W] = val;
      CFG_PATTERN_W2:    pat_bytes[2*CFG_W +: CFG_W] = val;
      CFG_PATTERN_W3:    pat_bytes[3*CFG_W +: CFG_W] = val;
      default: ;
    endcase
  endfunction

  function automatic int unsigned pattern_need();
    if (pat_len == '0) return 1;
    if (pat_len > MAX_PATTERN_LEN) return MAX_PATTERN_LEN;
    return int'(pat_len);
  endfunction

  function automatic result_t supervise_item(logic rt, logic [7:0] b);
    result_t     r;
    int unsigned need;
    int unsigned base;
    int unsigned i;
    logic        hit;
    r = '0;
    if (rt == REQ_BYTE) begin
      sup_idle = '0;
      if (sup_link == LINK_WAIT) begin
        if (sup_fill < MAX_PATTERN_LEN) begin
          sup_window[sup_fill] = b;
          sup_fill++;
        end else begin
          for (i = 0; i < MAX_PATTERN_LEN - 1; i++) sup_window[i] = sup_window[i + 1];
          sup_window[MAX_PATTERN_LEN - 1] = b;
        end
        need = pattern_need();
        if (sup_fill >= need) begin
          base = sup_fill - need;
          hit  = 1'b1;
          for (i = 0; i < need; i++) begin
            if (sup_window[base + i] != pat_bytes[i*8 +: 8]) hit = 1'b0;
          end
          if (hit) begin
            sup_link = LINK_UP;
            sup_fill = 0;
            r.handshake_matched = 1'b1;
          end
        end
      end
    end else begin
      if (sup_idle != IDLE_MAX) sup_idle++;
      if (sup_link == LINK_UP && sup_idle > {1'b0, lim_idle}) begin
        sup_link = LINK_WAIT;
        sup_fill = 0;
        sup_idle = '0;
        sup_wait = '0;
        r.idle_dropped = 1'b1;
      end
      if (sup_wait == '0) begin
        r.beacon_sent = 1'b1;
        r.beacon_kind = (sup_link == LINK_UP) ? BEACON_CONNECTED : BEACON_START_ROOT;
        sup_wait = (beacon_period == '0) ? '0 : beacon_period - 1'b1;
      end else begin
        sup_wait--;
      end
    end
    r.link_connected = (sup_link == LINK_UP);
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH at result %0d: %s got %0d want %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  // input side: predict every accepted transaction
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin : accept
      result_t guess;
      pin_t    pin;
      guess = supervise_item(in_req_type, in_rx_byte);
      pin = '0;
      if (pin_q.size() != 0) pin = pin_q.pop_front();
      pending_results.push_back(pin.on ? pin.want : guess);
    end
  end

  // output side: compare against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin : check
      result_t got;
      result_t want;
      got = {out_link_connected, out_handshake_matched, out_idle_dropped,
             out_beacon_sent, out_beacon_kind};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", got, 0);
      end else begin
        want = pending_results.pop_front();
        for (int i = 0; i < 5; i++) begin
          if (got[i] !== want[i]) report_mismatch(field_name[i], got[i], want[i]);
        end
        n_matched    += want.handshake_matched;
        n_dropped    += want.idle_dropped;
        n_beacons    += want.beacon_sent;
        n_beacons_up += want.beacon_sent & want.beacon_kind;
      end
      results_seen++;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 9);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
               stuck, items_sent - results_seen);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  task automatic push_item(logic rt, logic [7:0] b, logic on, result_t want);
    while (!quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pin_q.push_back({on, want});
    in_valid    <= 1'b1;
    in_req_type <= rt;
    in_rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t sel, logic [CFG_W-1:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    apply_reg(sel, val);
    cfg_we <= 1'b0;
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic program_regs(logic [15:0] lim, logic [15:0] per, logic [5:0] len,
                              logic [PAT_W-1:0] pat);
    write_reg(CFG_IDLE_LIMIT, CFG_W'(lim));
    write_reg(CFG_BEACON_PERIOD, CFG_W'(per));
    write_reg(CFG_PATTERN_LEN, CFG_W'(len));
    write_reg(CFG_PATTERN_W0, pat[0*CFG_W +: CFG_W]);
    write_reg(CFG_PATTERN_W1, pat[1*CFG_W +: CFG_W]);
    write_reg(CFG_PATTERN_W2, pat[2*CFG_W +: CFG_W]);
    write_reg(CFG_PATTERN_W3, pat[3*CFG_W +: CFG_W]);
  endtask

  function automatic void add_cfg(cfg_idx_t sel, logic [CFG_W-1:0] val);
    step_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.sel    = sel;
    r.wdata  = val;
    dir_steps.push_back(r);
  endfunction

  // want fields: link, matched, dropped, beacon, kind
  function automatic void add_item(logic rt, logic [7:0] b, logic on, logic [4:0] want);
    step_row_t r;
    r                  = '0;
    r.sel              = CFG_IDLE_LIMIT;
    r.item.req_type    = rt;
    r.item.rx_byte     = b;
    r.on               = on;
    r.want             = want;
    dir_steps.push_back(r);
  endfunction

  // handshake attempts (some corrupted), tick bursts and stray bytes
  task automatic run_phase(int unsigned n_items, logic pause_mid);
    int unsigned goal;
    int unsigned need;
    int unsigned bad;
    int unsigned burst;
    int unsigned pick;
    logic [7:0]  b;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      if (pause_mid && items_sent + n_items / 2 >= goal) begin
        pause_mid = 1'b0;
        drain();
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        need = pattern_need();
        repeat ($urandom_range(2)) push_item(REQ_BYTE, 8'($urandom_range(255)), 1'b0, '0);
        bad = ($urandom_range(99) < 20) ? $urandom_range(need - 1) : need;
        for (int k = 0; k < need; k++) begin
          b = pat_bytes[k*8 +: 8];
          if (k == bad) b ^= 8'(1 << $urandom_range(7));
          push_item(REQ_BYTE, b, 1'b0, '0);
        end
      end else if (pick < 88) begin
        burst = $urandom_range(1, ((lim_idle < 8) ? lim_idle : 8) + 3);
        repeat (burst) push_item(REQ_TICK, 8'($urandom_range(255)), 1'b0, '0);
      end else begin
        push_item(REQ_BYTE, 8'($urandom_range(255)), 1'b0, '0);
      end
    end
  endtask

  function automatic logic [PAT_W-1:0] random_pattern();
    return {$urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom};
  endfunction

  initial begin
    int unsigned rand_start;
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req_type = REQ_BYTE;
    in_rx_byte  = '0;
    out_stall   = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_IDLE_LIMIT;
    cfg_wdata   = '0;
    quiet       = 1'b0;
    hold_reqs   = 0;
    hold_seen   = 0;
    hold_left   = 0;
    stuck       = 0;
    reset_supervisor();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    add_item(REQ_TICK, 8'h00, 1'b1, 5'b0_0_0_1_0);   // beacon on first tick
    add_item(REQ_BYTE, 8'hFF, 1'b1, 5'b0_0_0_0_0);
    add_cfg(CFG_PATTERN_LEN, 64'd0);                 // zero length acts as one
    add_cfg(CFG_PATTERN_W0, 64'h0000_0000_0000_00A5);
    add_cfg(CFG_PATTERN_W1, '1);
    add_cfg(CFG_PATTERN_W2, '0);
    add_cfg(CFG_PATTERN_W3, 64'hAAAA_5555_AAAA_5555);
    add_cfg(CFG_IDLE_LIMIT, 64'd0);
    add_cfg(CFG_BEACON_PERIOD, 64'd0);
    add_item(REQ_BYTE, 8'h00, 1'b1, 5'b0_0_0_0_0);
    add_item(REQ_BYTE, 8'hA5, 1'b1, 5'b1_1_0_0_0);
    add_item(REQ_BYTE, 8'h12, 1'b1, 5'b1_0_0_0_0);
    add_item(REQ_TICK, 8'hFF, 1'b1, 5'b0_0_1_1_0);   // drop with immediate beacon
    add_item(REQ_TICK, 8'h5A, 1'b1, 5'b0_0_0_1_0);
    add_cfg(CFG_PATTERN_LEN, 64'd2);
    add_cfg(CFG_PATTERN_W0, 64'hFFFF_FFFF_FFFF_FF00);
    add_item(REQ_BYTE, 8'h00, 1'b1, 5'b0_0_0_0_0);
    add_item(REQ_BYTE, 8'hFF, 1'b1, 5'b1_1_0_0_0);
    add_cfg(CFG_IDLE_LIMIT, 64'hFFFF);
    add_cfg(CFG_BEACON_PERIOD, 64'hFFFF);
    add_item(REQ_TICK, 8'h00, 1'b1, 5'b1_0_0_1_1);
    add_item(REQ_TICK, 8'h00, 1'b1, 5'b1_0_0_0_0);
    add_cfg(CFG_IDLE_LIMIT, 64'd1);
    add_cfg(CFG_PATTERN_LEN, 64'd63);                // clamps to full window
    add_item(REQ_TICK, 8'h81, 1'b0, '0);
    add_item(REQ_BYTE, 8'h5A, 1'b0, '0);
    add_item(REQ_TICK, 8'h7E, 1'b0, '0);
    add_cfg(CFG_IDLE_LIMIT, 64'hDEAD_0000_0000_0002); // upper bits ignored
    add_cfg(CFG_PATTERN_LEN, 64'hFFFF_FFFF_FFFF_FFC1);
    add_item(REQ_BYTE, 8'h00, 1'b0, '0);
    add_item(REQ_TICK, 8'h01, 1'b0, '0);
    add_item(REQ_TICK, 8'h80, 1'b0, '0);
    add_item(REQ_TICK, 8'hC3, 1'b0, '0);

    foreach (dir_steps[n]) begin
      if (dir_steps[n].is_cfg) begin
        write_reg(dir_steps[n].sel, dir_steps[n].wdata);
      end else begin
        push_item(dir_steps[n].item.req_type, dir_steps[n].item.rx_byte,
                  dir_steps[n].on, dir_steps[n].want);
      end
    end

    rand_start = items_sent;
    phases = 0;
    while (items_sent - rand_start < RAND_ITEMS) begin
      case (phases)
        0: program_regs(16'd1, 16'd1, 6'd1, '0);
        1: program_regs(16'hFFFF, 16'hFFFF, 6'd32, '1);
        2: program_regs(16'd0, 16'd0, 6'd63, random_pattern());
        default: program_regs(16'($urandom_range(6)), 16'($urandom_range(12)),
                              ($urandom_range(7) == 0) ? 6'($urandom_range(9, 63))
                                                       : 6'($urandom_range(8)),
                              random_pattern());
      endcase
      quiet = (phases == 3);
      if (phases == 5) hold_reqs <= hold_reqs + 1;
      run_phase(PHASE_ITEMS, phases == 6);
      phases++;
    end

    drain();
    repeat (END_SLACK) @(posedge clk);
    $display("Run: %0d transactions in, %0d results checked, %0d register writes, %0d phases",
             items_sent, results_seen, cfg_writes, phases);
    $display("Seen: %0d handshakes, %0d idle drops, %0d beacons (%0d while connected)",
             n_matched, n_dropped, n_beacons, n_beacons_up);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
